### rtl/btcg_pkg.sv
// ----------------------------------------------------------------------------
// btcg_pkg
// Shared types, microcode and 5x7 font for the bitmap text character generator.
// ----------------------------------------------------------------------------
package btcg_pkg;

    localparam int COORD_BITS_DEF = 16;

    localparam int GLYPH_ROWS = 7;
    localparam int GLYPH_COLS = 5;
    localparam int GLYPH_DOTS = GLYPH_ROWS * GLYPH_COLS;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [3:0] ADV_DOTS     = 4'd6;   // pen advance per character, in dots
    localparam logic [3:0] LINE_DOTS    = 4'd9;   // line pitch, in dots

    localparam logic [4:0] SCALE_MIN = 5'd1;
    localparam logic [4:0] SCALE_MAX = 5'd16;

    typedef logic [2:0] t_upc;

    // microcode addresses
    localparam t_upc UPC_WAIT    = 3'd0;
    localparam t_upc UPC_LOAD    = 3'd1;
    localparam t_upc UPC_SCAN    = 3'd2;
    localparam t_upc UPC_ADVANCE = 3'd3;
    localparam t_upc UPC_NEWLINE = 3'd4;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_NEWLINE,
        COND_SCAN_BUSY
    } t_cond;

    // datapath controls carried by one microword
    typedef struct packed {
        logic in_ready;
        logic ld_glyph;
        logic scan_en;
        logic adv_pen;
        logic new_line;
    } t_ctrl;

    typedef struct packed {
        t_ctrl ctrl;
        t_cond cond;
        t_upc  target;
    } t_uword;

    // datapath flags the sequencer branches on
    typedef struct packed {
        logic accepted;
        logic is_newline;
        logic scan_done;
    } t_status;

    localparam t_uword UCODE_ROM [0:7] = '{
        // wait for a character, stay here until one is taken
        '{'{1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, COND_NO_INPUT,  UPC_WAIT},
        // origin load and glyph fetch, branch off for a newline
        '{'{1'b0, 1'b1, 1'b0, 1'b0, 1'b0}, COND_NEWLINE,   UPC_NEWLINE},
        // one dot per step until the last lit dot has gone
        '{'{1'b0, 1'b0, 1'b1, 1'b0, 1'b0}, COND_SCAN_BUSY, UPC_SCAN},
        '{'{1'b0, 1'b0, 1'b0, 1'b1, 1'b0}, COND_ALWAYS,    UPC_WAIT},
        '{'{1'b0, 1'b0, 1'b0, 1'b0, 1'b1}, COND_ALWAYS,    UPC_WAIT},
        '{'{1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, COND_ALWAYS,    UPC_WAIT},
        '{'{1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, COND_ALWAYS,    UPC_WAIT},
        '{'{1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, COND_ALWAYS,    UPC_WAIT}
    };

    // Glyph bitmap, top row first; bit 34 is the top left dot.
    function automatic logic [GLYPH_DOTS-1:0] glyph_rows(input logic [7:0] code);
        logic [7:0]            c;
        logic [GLYPH_DOTS-1:0] g;
        c = ((code >= "a") && (code <= "z")) ? (code - 8'd32) : code;
        unique case (c)
            "0": g = {5'h0e, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0e};
            "1": g = {5'h04, 5'h0c, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e};
            "2": g = {5'h0e, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1f};
            "3": g = {5'h1e, 5'h01, 5'h01, 5'h0e, 5'h01, 5'h01, 5'h1e};
            "4": g = {5'h02, 5'h06, 5'h0a, 5'h12, 5'h1f, 5'h02, 5'h02};
            "5": g = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h01, 5'h01, 5'h1e};
            "6": g = {5'h0e, 5'h10, 5'h10, 5'h1e, 5'h11, 5'h11, 5'h0e};
            "7": g = {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
            "8": g = {5'h0e, 5'h11, 5'h11, 5'h0e, 5'h11, 5'h11, 5'h0e};
            "9": g = {5'h0e, 5'h11, 5'h11, 5'h0f, 5'h01, 5'h01, 5'h0e};
            "A": g = {5'h0e, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11};
            "B": g = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h11, 5'h11, 5'h1e};
            "C": g = {5'h0e, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0e};
            "D": g = {5'h1e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1e};
            "E": g = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h1f};
            "F": g = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h10};
            "G": g = {5'h0e, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0f};
            "H": g = {5'h11, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11};
            "I": g = {5'h0e, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e};
            "J": g = {5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0c};
            "K": g = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
            "L": g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1f};
            "M": g = {5'h11, 5'h1b, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
            "N": g = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
            "O": g = {5'h0e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e};
            "P": g = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h10, 5'h10, 5'h10};
            "Q": g = {5'h0e, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0d};
            "R": g = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h14, 5'h12, 5'h11};
            "S": g = {5'h0f, 5'h10, 5'h10, 5'h0e, 5'h01, 5'h01, 5'h1e};
            "T": g = {5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            "U": g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e};
            "V": g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h0a, 5'h0a, 5'h04};
            "W": g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1b, 5'h11};
            "X": g = {5'h11, 5'h11, 5'h0a, 5'h04, 5'h0a, 5'h11, 5'h11};
            "Y": g = {5'h11, 5'h11, 5'h0a, 5'h04, 5'h04, 5'h04, 5'h04};
            "Z": g = {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1f};
            "+": g = {5'h00, 5'h04, 5'h04, 5'h1f, 5'h04, 5'h04, 5'h00};
            "-": g = {5'h00, 5'h00, 5'h00, 5'h1f, 5'h00, 5'h00, 5'h00};
            ".": g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0c, 5'h0c};
            ":": g = {5'h00, 5'h0c, 5'h0c, 5'h00, 5'h0c, 5'h0c, 5'h00};
            "/": g = {5'h01, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h10};
            "%": g = {5'h19, 5'h19, 5'h02, 5'h04, 5'h08, 5'h13, 5'h13};
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

### rtl/btcg_sequencer.sv
// ----------------------------------------------------------------------------
// btcg_sequencer
// Microprogram counter and control store; branches on datapath status.
// ----------------------------------------------------------------------------
module btcg_sequencer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  btcg_pkg::t_status i_status,
    output btcg_pkg::t_ctrl   o_ctrl
);

    btcg_pkg::t_upc   r_upc;
    btcg_pkg::t_upc   n_upc;
    btcg_pkg::t_uword uword;
    logic             take_jump;

    always_comb begin
        uword  = btcg_pkg::UCODE_ROM[r_upc];
        o_ctrl = uword.ctrl;
    end

    always_comb begin
        unique case (uword.cond)
            btcg_pkg::COND_NEVER:     take_jump = 1'b0;
            btcg_pkg::COND_ALWAYS:    take_jump = 1'b1;
            btcg_pkg::COND_NO_INPUT:  take_jump = !i_status.accepted;
            btcg_pkg::COND_NEWLINE:   take_jump = i_status.is_newline;
            btcg_pkg::COND_SCAN_BUSY: take_jump = !i_status.scan_done;
            default:                  take_jump = 1'b1;
        endcase
        n_upc = take_jump ? uword.target : btcg_pkg::t_upc'(r_upc + 3'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= btcg_pkg::UPC_WAIT;
        end else begin
            r_upc <= n_upc;
        end
    end

    a_accept_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.accepted |=> r_upc == btcg_pkg::UPC_LOAD)
        else $error("accepted character did not move on to glyph load");

    a_scan_done_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.scan_done |=> r_upc == btcg_pkg::UPC_ADVANCE)
        else $error("end of scan did not lead to pen advance");

endmodule

### rtl/btcg_datapath.sv
// ----------------------------------------------------------------------------
// btcg_datapath
// Pen registers, glyph shift register, saturating adders and output register.
// ----------------------------------------------------------------------------
module btcg_datapath #(
    parameter int COORD_BITS = btcg_pkg::COORD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  btcg_pkg::t_ctrl   i_ctrl,
    output btcg_pkg::t_status o_status,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_char_code,
    input  logic              i_first_of_text,
    input  logic signed [15:0] i_origin_x,
    input  logic signed [15:0] i_origin_y,
    input  logic [4:0]        i_dot_scale,
    input  logic [31:0]       i_ink_color,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic signed [15:0] o_square_x,
    output logic signed [15:0] o_square_y,
    output logic [4:0]        o_square_size,
    output logic [31:0]       o_square_color,
    output logic              o_last_square
);

    localparam int CB   = COORD_BITS;
    localparam int OW   = (CB > 16) ? CB : 16;
    localparam int DOTS = btcg_pkg::GLYPH_DOTS;
    localparam logic signed [CB-1:0] C_MAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] C_MIN = {1'b1, {(CB-1){1'b0}}};

    function automatic logic signed [CB-1:0] sat_add(input logic signed [CB-1:0] base,
                                                     input logic [7:0] off);
        logic signed [CB+1:0] sum;
        logic [2:0]           top;
        sum = (CB+2)'(base) + (CB+2)'($signed({1'b0, off}));
        top = sum[CB+1:CB-1];
        if ((&top) || !(|top)) begin
            return sum[CB-1:0];
        end
        return sum[CB+1] ? C_MIN : C_MAX;
    endfunction

    function automatic logic signed [CB-1:0] sat_origin(input logic signed [15:0] v);
        logic signed [OW-1:0] ext;
        logic [OW-CB:0]       top;
        ext = OW'(v);
        top = ext[OW-1:CB-1];
        if ((&top) || !(|top)) begin
            return ext[CB-1:0];
        end
        return ext[OW-1] ? C_MIN : C_MAX;
    endfunction

    // latched character
    logic [7:0]         r_code;
    logic               r_first;
    logic signed [15:0] r_org_x;
    logic signed [15:0] r_org_y;
    logic [4:0]         r_scale;
    logic [31:0]        r_color;

    // pen state
    logic signed [CB-1:0] r_pen_x;
    logic signed [CB-1:0] r_pen_y;
    logic signed [CB-1:0] r_line_x;

    // dot scan
    logic [DOTS-1:0] r_dots;
    logic [2:0]      r_col;
    logic [2:0]      r_row;

    logic               r_out_valid;
    logic signed [15:0] r_sq_x;
    logic signed [15:0] r_sq_y;
    logic [4:0]         r_sq_size;
    logic [31:0]        r_sq_color;
    logic               r_sq_last;

    logic                 accepted;
    logic [4:0]           scale_in;
    logic                 cur_lit;
    logic                 rest_empty;
    logic                 out_free;
    logic                 step_go;
    logic                 emit;
    logic signed [CB-1:0] pen_x_ld;
    logic signed [CB-1:0] dot_x;
    logic signed [CB-1:0] dot_y;

    assign o_in_ready = i_ctrl.in_ready;
    assign accepted   = i_in_valid && i_ctrl.in_ready;

    always_comb begin
        if (i_dot_scale < btcg_pkg::SCALE_MIN) begin
            scale_in = btcg_pkg::SCALE_MIN;
        end else if (i_dot_scale > btcg_pkg::SCALE_MAX) begin
            scale_in = btcg_pkg::SCALE_MAX;
        end else begin
            scale_in = i_dot_scale;
        end
    end

    assign cur_lit    = r_dots[DOTS-1];
    assign rest_empty = (r_dots[DOTS-2:0] == '0);
    assign out_free   = !r_out_valid || i_out_ready;
    assign step_go    = i_ctrl.scan_en && (!cur_lit || out_free);
    assign emit       = step_go && cur_lit;

    assign pen_x_ld = sat_origin(r_org_x);
    assign dot_x    = sat_add(r_pen_x, 8'(r_col * r_scale));
    assign dot_y    = sat_add(r_pen_y, 8'(r_row * r_scale));

    assign o_status.accepted   = accepted;
    assign o_status.is_newline = (r_code == btcg_pkg::CHAR_NEWLINE);
    assign o_status.scan_done  = step_go && rest_empty;

    always_ff @(posedge i_clk) begin
        if (accepted) begin
            r_code  <= i_char_code;
            r_first <= i_first_of_text;
            r_org_x <= i_origin_x;
            r_org_y <= i_origin_y;
            r_scale <= scale_in;
            r_color <= i_ink_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x  <= '0;
            r_pen_y  <= '0;
            r_line_x <= '0;
        end else if (i_ctrl.ld_glyph && r_first) begin
            r_pen_x  <= pen_x_ld;
            r_line_x <= pen_x_ld;
            r_pen_y  <= sat_origin(r_org_y);
        end else if (i_ctrl.new_line) begin
            r_pen_x <= r_line_x;
            r_pen_y <= sat_add(r_pen_y, 8'(r_scale * btcg_pkg::LINE_DOTS));
        end else if (i_ctrl.adv_pen) begin
            r_pen_x <= sat_add(r_pen_x, 8'(r_scale * btcg_pkg::ADV_DOTS));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld_glyph) begin
            r_dots <= btcg_pkg::glyph_rows(r_code);
            r_col  <= '0;
            r_row  <= '0;
        end else if (step_go) begin
            r_dots <= {r_dots[DOTS-2:0], 1'b0};
            if (r_col == 3'(btcg_pkg::GLYPH_COLS - 1)) begin
                r_col <= '0;
                r_row <= r_row + 3'd1;
            end else begin
                r_col <= r_col + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_sq_x     <= 16'(dot_x);
            r_sq_y     <= 16'(dot_y);
            r_sq_size  <= r_scale;
            r_sq_color <= r_color;
            r_sq_last  <= rest_empty;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_square_x     = r_sq_x;
    assign o_square_y     = r_sq_y;
    assign o_square_size  = r_sq_size;
    assign o_square_color = r_sq_color;
    assign o_last_square  = r_sq_last;

    a_scan_holds_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.scan_en && cur_lit && r_out_valid && !i_out_ready) |=> $stable(r_dots))
        else $error("lit dot dropped while the output register was full");

    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> r_out_valid && (r_sq_size == $past(r_scale)))
        else $error("emitted square not presented");

endmodule

### rtl/bitmap_text_character_generator_top.sv
// ----------------------------------------------------------------------------
// bitmap_text_character_generator_top
// 5x7 dot-matrix text to filled squares, one text byte per transaction.
// ----------------------------------------------------------------------------
// Send text one byte per input transaction; set tuser on the first byte of a
// text to load origin_x/origin_y as pen and line start. Lower case is folded
// to upper case; digits, letters and + - . : / % have glyphs, all else is a
// blank that still advances the pen. Each lit dot comes out as one square
// transaction of side dot_scale (clamped to 1..16), tlast on the last square
// of the character; the pen then moves right 6*scale pixels. Byte 10 is a
// newline: pen back to line start and 9*scale rows down, nothing emitted.
// Coordinates are held in COORD_BITS and saturate; outputs carry the low
// 16 bits. A small microcoded sequencer walks the glyph one dot per cycle,
// holding on a lit dot while the output register is full, and stops after
// the last lit dot of the character. The next byte is taken while the last
// square still waits in the output register.
// ----------------------------------------------------------------------------
module bitmap_text_character_generator_top #(
    parameter int COORD_BITS = btcg_pkg::COORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] char_code, [23:8] origin_x, [39:24] origin_y,
    // [44:40] dot_scale, [76:45] ink_color, [79:77] zero
    input  logic [79:0] s_axis_tdata,
    // [0] first_of_text
    input  logic [0:0]  s_axis_tuser,
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] square_x, [31:16] square_y, [36:32] square_size,
    // [68:37] square_color, [71:69] zero
    output logic [71:0] m_axis_tdata,
    output logic        m_axis_tlast    // last_square
);

    btcg_pkg::t_ctrl   ctrl;
    btcg_pkg::t_status status;

    logic signed [15:0] sq_x;
    logic signed [15:0] sq_y;
    logic [4:0]         sq_size;
    logic [31:0]        sq_color;

    // control store and step counter
    btcg_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    // pen, glyph scan and output register
    btcg_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (ctrl),
        .o_status        (status),
        .i_in_valid      (s_axis_tvalid),
        .o_in_ready      (s_axis_tready),
        .i_char_code     (s_axis_tdata[7:0]),
        .i_first_of_text (s_axis_tuser[0]),
        .i_origin_x      (s_axis_tdata[23:8]),
        .i_origin_y      (s_axis_tdata[39:24]),
        .i_dot_scale     (s_axis_tdata[44:40]),
        .i_ink_color     (s_axis_tdata[76:45]),
        .o_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .o_square_x      (sq_x),
        .o_square_y      (sq_y),
        .o_square_size   (sq_size),
        .o_square_color  (sq_color),
        .o_last_square   (m_axis_tlast)
    );

    // pack the square, first field lowest
    assign m_axis_tdata = {3'b000, sq_color, sq_size, sq_y, sq_x};

endmodule

### tb/sv/bitmap_text_character_generator_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_text_character_generator_top_test
// Self-checking bench for the 5x7 dot-matrix text generator.
// ----------------------------------------------------------------------------
// Sends text bytes over the input stream and tracks pen, line start and font
// lookup on the bench side. For every accepted byte it works out the squares
// the block should draw and checks each output transaction against them, in
// order. A directed opening covers part of the glyph set, case folding, blanks, high
// codes, newlines, scale clamping and coordinate saturation. Random texts
// follow, run under four idling mixes on the two stream sides.
// ----------------------------------------------------------------------------
module bitmap_text_character_generator_top_test;

    localparam int    IDLE_LIMIT   = 4000;  // cycles without any transaction
    localparam int    DRAIN_CYCLES = 48;
    localparam int    PHASE_ITEMS  = 27;
    localparam string GLYPH_CODES  = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ+-.:/%";

    // ------------------------------------------------------------------------
    // Expected-square tracker: pen state, font and the queue of squares due
    // ------------------------------------------------------------------------
    class square_predictor;
        typedef struct packed {
            logic [15:0] x;
            logic [15:0] y;
            logic [4:0]  size;
            logic [31:0] color;
            logic        last;
        } t_square;

        logic [btcg_pkg::GLYPH_DOTS-1:0] font [logic [7:0]];
        t_square pending_squares [$];
        int pen_x;
        int pen_y;
        int line_x;
        int failures;

        function new();
            pen_x    = 0;
            pen_y    = 0;
            line_x   = 0;
            failures = 0;
            font["0"] = {5'h0e, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0e};
            font["1"] = {5'h04, 5'h0c, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e};
            font["2"] = {5'h0e, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1f};
            font["3"] = {5'h1e, 5'h01, 5'h01, 5'h0e, 5'h01, 5'h01, 5'h1e};
            font["4"] = {5'h02, 5'h06, 5'h0a, 5'h12, 5'h1f, 5'h02, 5'h02};
            font["5"] = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h01, 5'h01, 5'h1e};
            font["6"] = {5'h0e, 5'h10, 5'h10, 5'h1e, 5'h11, 5'h11, 5'h0e};
            font["7"] = {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
            font["8"] = {5'h0e, 5'h11, 5'h11, 5'h0e, 5'h11, 5'h11, 5'h0e};
            font["9"] = {5'h0e, 5'h11, 5'h11, 5'h0f, 5'h01, 5'h01, 5'h0e};
            font["A"] = {5'h0e, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11};
            font["B"] = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h11, 5'h11, 5'h1e};
            font["C"] = {5'h0e, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0e};
            font["D"] = {5'h1e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1e};
            font["E"] = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h1f};
            font["F"] = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h10};
            font["G"] = {5'h0e, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0f};
            font["H"] = {5'h11, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11};
            font["I"] = {5'h0e, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e};
            font["J"] = {5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0c};
            font["K"] = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
            font["L"] = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1f};
            font["M"] = {5'h11, 5'h1b, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
            font["N"] = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
            font["O"] = {5'h0e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e};
            font["P"] = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h10, 5'h10, 5'h10};
            font["Q"] = {5'h0e, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0d};
            font["R"] = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h14, 5'h12, 5'h11};
            font["S"] = {5'h0f, 5'h10, 5'h10, 5'h0e, 5'h01, 5'h01, 5'h1e};
            font["T"] = {5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            font["U"] = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e};
            font["V"] = {5'h11, 5'h11, 5'h11, 5'h11, 5'h0a, 5'h0a, 5'h04};
            font["W"] = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1b, 5'h11};
            font["X"] = {5'h11, 5'h11, 5'h0a, 5'h04, 5'h0a, 5'h11, 5'h11};
            font["Y"] = {5'h11, 5'h11, 5'h0a, 5'h04, 5'h04, 5'h04, 5'h04};
            font["Z"] = {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1f};
            font["+"] = {5'h00, 5'h04, 5'h04, 5'h1f, 5'h04, 5'h04, 5'h00};
            font["-"] = {5'h00, 5'h00, 5'h00, 5'h1f, 5'h00, 5'h00, 5'h00};
            font["."] = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0c, 5'h0c};
            font[":"] = {5'h00, 5'h0c, 5'h0c, 5'h00, 5'h0c, 5'h0c, 5'h00};
            font["/"] = {5'h01, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h10};
            font["%"] = {5'h19, 5'h19, 5'h02, 5'h04, 5'h08, 5'h13, 5'h13};
        endfunction

        static function int sat16(int v);
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return v;
        endfunction

        function int pending();
            return pending_squares.size();
        endfunction

        // Note one accepted character: update the pen, queue its squares
        function void take_char(logic [7:0] code, logic first, logic [15:0] ox,
                                logic [15:0] oy, logic [4:0] scale_in,
                                logic [31:0] ink);
            int                              s;
            int                              left;
            logic [7:0]                      c;
            logic [btcg_pkg::GLYPH_DOTS-1:0] dots;
            t_square                         sq;
            s = (scale_in < btcg_pkg::SCALE_MIN) ? int'(btcg_pkg::SCALE_MIN) :
                (scale_in > btcg_pkg::SCALE_MAX) ? int'(btcg_pkg::SCALE_MAX) :
                int'(scale_in);
            if (first) begin
                pen_x  = int'($signed(ox));
                line_x = pen_x;
                pen_y  = int'($signed(oy));
            end
            if (code == btcg_pkg::CHAR_NEWLINE) begin
                pen_x = line_x;
                pen_y = sat16(pen_y + int'(btcg_pkg::LINE_DOTS) * s);
                return;
            end
            c    = (code >= "a" && code <= "z") ? code - 8'd32 : code;
            dots = font.exists(c) ? font[c] : '0;
            left = $countones(dots);
            // scan top row first, left to right; top left dot is the MSB
            for (int r = 0; r < btcg_pkg::GLYPH_ROWS; r++) begin
                for (int k = 0; k < btcg_pkg::GLYPH_COLS; k++) begin
                    if (dots[btcg_pkg::GLYPH_DOTS - 1 - (r * btcg_pkg::GLYPH_COLS + k)]) begin
                        left--;
                        sq.x     = 16'(sat16(pen_x + k * s));
                        sq.y     = 16'(sat16(pen_y + r * s));
                        sq.size  = 5'(s);
                        sq.color = ink;
                        sq.last  = (left == 0);
                        pending_squares = {pending_squares, sq};
                    end
                end
            end
            pen_x = sat16(pen_x + int'(btcg_pkg::ADV_DOTS) * s);
        endfunction

        // Check one output transaction against the oldest square due
        function void match_square(logic [71:0] data, logic last);
            t_square want;
            if (pending_squares.size() == 0) begin
                $error("unexpected square x=%0d y=%0d", $signed(data[15:0]),
                       $signed(data[31:16]));
                failures++;
                return;
            end
            want = pending_squares.pop_front();
            if (data[15:0] !== want.x) begin
                $error("square_x: expected %0d, got %0d", $signed(want.x),
                       $signed(data[15:0]));
                failures++;
            end
            if (data[31:16] !== want.y) begin
                $error("square_y: expected %0d, got %0d", $signed(want.y),
                       $signed(data[31:16]));
                failures++;
            end
            if (data[36:32] !== want.size) begin
                $error("square_size: expected %0d, got %0d", want.size, data[36:32]);
                failures++;
            end
            if (data[68:37] !== want.color) begin
                $error("square_color: expected %h, got %h", want.color, data[68:37]);
                failures++;
            end
            if (last !== want.last) begin
                $error("last_square: expected %0b, got %0b", want.last, last);
                failures++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [7:0] char_code, [23:8] origin_x, [39:24] origin_y,
    // [44:40] dot_scale, [76:45] ink_color, [79:77] zero
    logic [79:0] s_axis_tdata  = '0;
    // [0] first_of_text
    logic [0:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [15:0] square_x, [31:16] square_y, [36:32] square_size,
    // [68:37] square_color, [71:69] zero
    logic [71:0] m_axis_tdata;
    logic        m_axis_tlast;   // last_square

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    square_predictor squares = new();

    always #4 i_clk = ~i_clk;

    bitmap_text_character_generator_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Output side: stall at random for the current idling mix
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor both streams at the edge. Note the input first; its squares
    // cannot appear before the next edge, so the order here is harmless.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                squares.take_char(s_axis_tdata[7:0], s_axis_tuser[0],
                                  s_axis_tdata[23:8], s_axis_tdata[39:24],
                                  s_axis_tdata[44:40], s_axis_tdata[76:45]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                squares.match_square(m_axis_tdata, m_axis_tlast);
            end
        end
    end

    // Watchdog: give up when neither stream moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("[bitmap_text_character_generator_top] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Present one character and hold it until the transaction completes.
    // Valid stays high between back-to-back characters.
    task automatic send_char(input logic [7:0] code, input logic first,
                             input logic [15:0] ox, input logic [15:0] oy,
                             input logic [4:0] scale, input logic [31:0] ink);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, ink, scale, oy, ox, code};
        s_axis_tuser  <= first;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Origins: anywhere, hard against either rail, or near zero
    function automatic logic [15:0] pick_coord();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'h7fff - 16'($urandom_range(200));
            2: return 16'h8000 + 16'($urandom_range(200));
            default: return 16'($urandom_range(400)) - 16'd200;
        endcase
    endfunction

    // Mostly glyph characters in either case, some newlines, some raw bytes
    function automatic logic [7:0] pick_char();
        int         k;
        logic [7:0] c;
        k = $urandom_range(99);
        if (k < 70) begin
            c = GLYPH_CODES[$urandom_range(GLYPH_CODES.len() - 1)];
            if (c >= "A" && c <= "Z" && $urandom_range(1)) c = c + 8'd32;
            return c;
        end
        if (k < 82) return btcg_pkg::CHAR_NEWLINE;
        return 8'($urandom_range(255));
    endfunction

    // Random texts: origin flag on the first byte, occasionally mid-text too
    task automatic random_texts(input int budget);
        int          sent;
        int          len;
        logic [15:0] ox;
        logic [15:0] oy;
        logic [4:0]  sc;
        logic [31:0] ink;
        sent = 0;
        while (sent < budget) begin
            ox  = pick_coord();
            oy  = pick_coord();
            sc  = ($urandom_range(9) == 0) ? 5'($urandom_range(31))
                                           : 5'($urandom_range(16, 1));
            ink = $urandom;
            len = $urandom_range(8, 1);
            for (int i = 0; i < len && sent < budget; i++) begin
                send_char(pick_char(), (i == 0) || ($urandom_range(19) == 0),
                          ox, oy, sc, ($urandom_range(3) == 0) ? $urandom : ink);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed opening, no idling on either side
        send_char("A", 1'b1, 16'd0, 16'd0, 5'd1, 32'hffff_ffff);
        send_char("b", 1'b0, 16'd0, 16'd0, 5'd1, 32'h0000_0000);
        send_char("8", 1'b0, 16'd0, 16'd0, 5'd16, $urandom);
        send_char(btcg_pkg::CHAR_NEWLINE, 1'b0, 16'd0, 16'd0, 5'd2, $urandom);
        send_char("%", 1'b0, 16'd0, 16'd0, 5'd3, $urandom);
        send_char("+", 1'b0, 16'd0, 16'd0, 5'd3, $urandom);
        send_char("-", 1'b0, 16'd0, 16'd0, 5'd3, $urandom);
        send_char(".", 1'b0, 16'd0, 16'd0, 5'd3, $urandom);
        send_char(":", 1'b0, 16'd0, 16'd0, 5'd3, $urandom);
        send_char("/", 1'b0, 16'd0, 16'd0, 5'd3, $urandom);
        send_char("0", 1'b0, 16'd0, 16'd0, 5'd2, $urandom);
        send_char("9", 1'b0, 16'd0, 16'd0, 5'd2, $urandom);
        send_char("z", 1'b0, 16'd0, 16'd0, 5'd5, $urandom);
        // blanks: unknown glyph and high codes still move the pen
        send_char("#", 1'b0, 16'd0, 16'd0, 5'd4, $urandom);
        send_char(8'd255, 1'b0, 16'd0, 16'd0, 5'd4, $urandom);
        send_char(8'd128, 1'b0, 16'd0, 16'd0, 5'd4, $urandom);
        // scale clamping at both ends
        send_char("W", 1'b0, 16'd0, 16'd0, 5'd0, $urandom);
        send_char("M", 1'b0, 16'd0, 16'd0, 5'd17, $urandom);
        send_char("Q", 1'b0, 16'd0, 16'd0, 5'd31, $urandom);
        // saturation against the top rail, then a newline past it
        send_char("H", 1'b1, 16'h7fff, 16'h7ff0, 5'd16, $urandom);
        send_char(btcg_pkg::CHAR_NEWLINE, 1'b0, 16'd0, 16'd0, 5'd16, $urandom);
        send_char("X", 1'b0, 16'd0, 16'd0, 5'd16, $urandom);
        // newline carrying an origin load at the bottom rail
        send_char(btcg_pkg::CHAR_NEWLINE, 1'b1, 16'h8000, 16'h8000, 5'd4, $urandom);
        send_char("O", 1'b0, 16'd0, 16'd0, 5'd1, $urandom);

        // random texts under each idling mix
        random_texts(PHASE_ITEMS);
        send_idle_pct  = 81;
        random_texts(PHASE_ITEMS);
        send_idle_pct  = 0;
        recv_stall_pct = 81;
        random_texts(PHASE_ITEMS);
        send_idle_pct  = 30;
        recv_stall_pct = 30;
        random_texts(PHASE_ITEMS);

        // drop valid, let every square due drain, then allow for stragglers
        s_axis_tvalid <= 1'b0;
        while (squares.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (squares.failures == 0) begin
            $display("[bitmap_text_character_generator_top] OK");
        end else begin
            $display("[bitmap_text_character_generator_top] ERROR");
        end
        $finish;
    end

endmodule
